### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CCT_ASSERT_NOW(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define CCT_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

### rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Types, Q24 constants and helper functions for the colour temperature block.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

    localparam int OUT_BITS_DEF = 16;

    typedef logic signed [31:0] q_t;

    typedef enum logic [2:0] {
        BAND_LOW  = 3'd0,
        BAND_A    = 3'd1,
        BAND_B    = 3'd2,
        BAND_C    = 3'd3,
        BAND_HIGH = 3'd4
    } band_t;

    typedef struct packed {
        q_t c3;
        q_t c2;
        q_t c1;
        q_t c0;
    } coef_t;

    localparam logic signed [63:0] QS   = 64'sd16777216;
    localparam logic signed [63:0] H7   = 64'sd5000000;
    localparam logic signed [63:0] D7   = 64'sd10000000;
    localparam logic signed [63:0] H6   = 64'sd500000;
    localparam logic signed [63:0] D6   = 64'sd1000000;
    localparam logic signed [63:0] H3   = 64'sd500;
    localparam logic signed [63:0] D3   = 64'sd1000;

    localparam q_t QONE = 32'sd16777216;

    localparam logic [33:0] U_NUM = 34'd16777216000;
    localparam logic [15:0] T_MIN = 16'd1000;
    localparam logic [15:0] T_MAX = 16'd40000;

    localparam q_t XA3 = -q_t'((64'sd2661239 * QS + H7) / D7);
    localparam q_t XA2 = -q_t'((64'sd2343580 * QS + H7) / D7);
    localparam q_t XA1 =  q_t'((64'sd8776956 * QS + H7) / D7);
    localparam q_t XA0 =  q_t'((64'sd179910 * QS + H6) / D6);
    localparam q_t XB3 = -q_t'((64'sd30258469 * QS + H7) / D7);
    localparam q_t XB2 =  q_t'((64'sd21070379 * QS + H7) / D7);
    localparam q_t XB1 =  q_t'((64'sd2226347 * QS + H7) / D7);
    localparam q_t XB0 =  q_t'((64'sd240390 * QS + H6) / D6);

    localparam q_t YA3 = -q_t'((64'sd11063814 * QS + H7) / D7);
    localparam q_t YA2 = -q_t'((64'sd13481102 * QS + H7) / D7);
    localparam q_t YA1 =  q_t'((64'sd21855580 * QS + H7) / D7);
    localparam q_t YA0 = -q_t'((64'sd202196 * QS + H6) / D6);
    localparam q_t YB3 = -q_t'((64'sd9549476 * QS + H7) / D7);
    localparam q_t YB2 = -q_t'((64'sd13741859 * QS + H7) / D7);
    localparam q_t YB1 =  q_t'((64'sd20913701 * QS + H7) / D7);
    localparam q_t YB0 = -q_t'((64'sd167488 * QS + H6) / D6);
    localparam q_t YC3 =  q_t'((64'sd30817580 * QS + H7) / D7);
    localparam q_t YC2 = -q_t'((64'sd58733867 * QS + H7) / D7);
    localparam q_t YC1 =  q_t'((64'sd3751129 * QS + H6) / D6);
    localparam q_t YC0 = -q_t'((64'sd370015 * QS + H6) / D6);

    localparam q_t MRX =  q_t'((64'sd32404542 * QS + H7) / D7);
    localparam q_t MRY = -q_t'((64'sd15371385 * QS + H7) / D7);
    localparam q_t MRZ = -q_t'((64'sd4985314 * QS + H7) / D7);
    localparam q_t MGX = -q_t'((64'sd9692660 * QS + H7) / D7);
    localparam q_t MGY =  q_t'((64'sd18760108 * QS + H7) / D7);
    localparam q_t MGZ =  q_t'((64'sd415560 * QS + H7) / D7);
    localparam q_t MBX =  q_t'((64'sd556434 * QS + H7) / D7);
    localparam q_t MBY = -q_t'((64'sd2040259 * QS + H7) / D7);
    localparam q_t MBZ =  q_t'((64'sd10572252 * QS + H7) / D7);

    localparam q_t X_HIGH = q_t'((64'sd239 * QS + H3) / D3);
    localparam q_t X_LOW  = q_t'((64'sd642 * QS + H3) / D3);
    localparam q_t Y_HIGH = q_t'((64'sd246 * QS + H3) / D3);
    localparam q_t Y_LOW  = q_t'((64'sd376 * QS + H3) / D3);

    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [63:0] p;
        logic [63:0]        m;
        logic [63:0]        r;
        p = 64'(a) * 64'(b);
        m = p[63] ? 64'(-p) : 64'(p);
        r = (m + 64'd8388608) >> 24;
        qmul = p[63] ? -q_t'(r) : q_t'(r);
    endfunction

    function automatic band_t band_of(input logic [15:0] t);
        if (t < 16'd1667)
            band_of = BAND_LOW;
        else if (t <= 16'd2222)
            band_of = BAND_A;
        else if (t <= 16'd4000)
            band_of = BAND_B;
        else if (t <= 16'd25000)
            band_of = BAND_C;
        else
            band_of = BAND_HIGH;
    endfunction

    function automatic coef_t x_coef(input band_t b);
        coef_t c;
        unique case (b) inside
            BAND_A, BAND_B: c = '{XA3, XA2, XA1, XA0};
            default:        c = '{XB3, XB2, XB1, XB0};
        endcase
        x_coef = c;
    endfunction

    function automatic coef_t y_coef(input band_t b);
        coef_t c;
        unique case (b)
            BAND_A:  c = '{YA3, YA2, YA1, YA0};
            BAND_B:  c = '{YB3, YB2, YB1, YB0};
            default: c = '{YC3, YC2, YC1, YC0};
        endcase
        y_coef = c;
    endfunction

    function automatic q_t x_pick(input band_t b, input q_t v);
        q_t r;
        unique case (b)
            BAND_LOW:  r = X_LOW;
            BAND_HIGH: r = X_HIGH;
            default:   r = v;
        endcase
        x_pick = r;
    endfunction

    function automatic q_t y_pick(input band_t b, input q_t v);
        q_t r;
        unique case (b)
            BAND_LOW:  r = Y_LOW;
            BAND_HIGH: r = Y_HIGH;
            default:   r = v;
        endcase
        y_pick = r;
    endfunction

endpackage

`default_nettype wire

### rtl/cct_div.sv
// ----------------------------------------------------------------------------
// cct_div
// Pipelined restoring divider: one quotient bit per stage, shared divisor
// across lanes, side data carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_div import cct_pkg::*; #(
    parameter int NW     = 34,
    parameter int DW     = 16,
    parameter int QB     = 25,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       in_vld,
    input  wire logic [LANES-1:0][NW-1:0]   num,
    input  wire logic [DW-1:0]              den,
    input  wire logic [SIDE_W-1:0]          side_in,
    output logic                            out_vld,
    output logic [LANES-1:0][QB-1:0]        quo,
    output logic [SIDE_W-1:0]               side_out
);

    logic [DW-1:0]     rem_reg [QB][LANES];
    logic [QB-1:0]     low_reg [QB][LANES];
    logic [QB-1:0]     quo_reg [QB][LANES];
    logic [DW-1:0]     den_reg [QB];
    logic [SIDE_W-1:0] side_reg [QB];
    logic [QB-1:0]     vld_reg;

    logic [DW-1:0]     rem_in [QB][LANES];
    logic [QB-1:0]     low_in [QB][LANES];
    logic [QB-1:0]     quo_in [QB][LANES];
    logic [DW-1:0]     den_in [QB];
    logic [SIDE_W-1:0] side_in_s [QB];
    logic [QB-1:0]     vld_in;

    for (genvar s = 0; s < QB; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign den_in[s]    = den;
            assign side_in_s[s] = side_in;
            assign vld_in[s]    = in_vld;
        end else begin : g_rest
            assign den_in[s]    = den_reg[s-1];
            assign side_in_s[s] = side_reg[s-1];
            assign vld_in[s]    = vld_reg[s-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [NW+DW-1:0] ext;
            logic [DW:0]      cand;
            logic             ge;

            assign ext = {{DW{1'b0}}, num[l]};

            if (s == 0) begin : g_first
                assign rem_in[s][l] = ext[QB +: DW];
                assign low_in[s][l] = num[l][QB-1:0];
                assign quo_in[s][l] = '0;
            end else begin : g_rest
                assign rem_in[s][l] = rem_reg[s-1][l];
                assign low_in[s][l] = low_reg[s-1][l];
                assign quo_in[s][l] = quo_reg[s-1][l];
            end

            assign cand = {rem_in[s][l], low_in[s][l][QB-1]};
            assign ge   = cand >= {1'b0, den_in[s]};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[s][l] <= ge ? (cand[DW-1:0] - den_in[s]) : cand[DW-1:0];
                    low_reg[s][l] <= {low_in[s][l][QB-2:0], 1'b0};
                    quo_reg[s][l] <= {quo_in[s][l][QB-2:0], ge};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[s]  <= den_in[s];
                side_reg[s] <= side_in_s[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (adv)
                vld_reg[s] <= vld_in[s];
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign quo[l] = quo_reg[QB-1][l];
    end

    assign out_vld  = vld_reg[QB-1];
    assign side_out = side_reg[QB-1];

endmodule

`default_nettype wire

### rtl/cct_cubic.sv
// ----------------------------------------------------------------------------
// cct_cubic
// Three-stage Horner evaluation of a Q24 cubic, one multiply per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_cubic import cct_pkg::*; #(
    parameter int SIDE_W = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_vld,
    input  wire q_t                v,
    input  wire coef_t             coef,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_vld,
    output q_t                     res,
    output logic [SIDE_W-1:0]      side_out
);

    q_t                v1_reg, a1_reg, c1_reg, c01_reg;
    q_t                v2_reg, a2_reg, c02_reg;
    q_t                a3_reg;
    logic [SIDE_W-1:0] s1_reg, s2_reg, s3_reg;
    logic [2:0]        vld_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_reg  <= v;
            a1_reg  <= qmul(coef.c3, v) + coef.c2;
            c1_reg  <= coef.c1;
            c01_reg <= coef.c0;
            s1_reg  <= side_in;

            v2_reg  <= v1_reg;
            a2_reg  <= qmul(a1_reg, v1_reg) + c1_reg;
            c02_reg <= c01_reg;
            s2_reg  <= s1_reg;

            a3_reg  <= qmul(a2_reg, v2_reg) + c02_reg;
            s3_reg  <= s2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[1:0], in_vld};
    end

    assign out_vld  = vld_reg[2];
    assign res      = a3_reg;
    assign side_out = s3_reg;

endmodule

`default_nettype wire

### rtl/color_temperature_to_rgb.sv
// Throughput: one beat per cycle while in_stall is low; every stage holds
// one item, so the dividers (one quotient bit per stage) and cubics run
// fully pipelined. A stalled output parks one result in a skid register;
// input stall rises only while that register is full.
// Reset clears every valid bit; no datapath register is reset.
`default_nettype none
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// color_temperature_to_rgb
// Colour temperature in kelvin to linear sRGB via a Planckian locus fit.
// ----------------------------------------------------------------------------
module color_temperature_to_rgb import cct_pkg::*; #(
    parameter int OUT_BITS = OUT_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [15:0]         kelvin,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [OUT_BITS-1:0]      red,
    output logic [OUT_BITS-1:0]      green,
    output logic [OUT_BITS-1:0]      blue
);

    localparam logic [63:0] OUT_TOP = (64'd1 << OUT_BITS) - 64'd1;

    function automatic logic [OUT_BITS-1:0] to_out(input q_t v);
        logic [63:0] sc;
        if (v <= 0)
            to_out = '0;
        else
        begin
            sc = ((64'(v) << OUT_BITS) + 64'd8388608) >> 24;
            to_out = (sc > OUT_TOP) ? OUT_TOP[OUT_BITS-1:0] : sc[OUT_BITS-1:0];
        end
    endfunction

    logic adv;
    logic out_valid_reg, skid_valid_reg;
    logic [2:0][OUT_BITS-1:0] out_reg, skid_reg;

    assign adv = !skid_valid_reg;

    // clamp and reciprocal
    logic [15:0]        kel_c;
    band_t              band_in;
    logic [0:0][33:0]   u_num;
    logic               u_vld;
    logic [0:0][24:0]   u_quo;
    logic [2:0]         u_side;

    always_comb
    begin
        kel_c = kelvin;
        if (kelvin < T_MIN)
            kel_c = T_MIN;
        else if (kelvin > T_MAX)
            kel_c = T_MAX;
    end

    assign band_in  = band_of(kel_c);
    assign u_num[0] = U_NUM + 34'(kel_c >> 1);

    cct_div #(
        .NW(34), .DW(16), .QB(25), .LANES(1), .SIDE_W(3)
    ) u_div_recip (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_vld(in_valid), .num(u_num), .den(kel_c), .side_in(band_in),
        .out_vld(u_vld), .quo(u_quo), .side_out(u_side)
    );

    // chromaticity x
    logic  x_vld;
    q_t    x_raw;
    logic [2:0] x_side;
    band_t x_band;
    q_t    x_sel;

    cct_cubic #(.SIDE_W(3)) u_cubic_x (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_vld(u_vld), .v(q_t'({7'd0, u_quo[0]})), .coef(x_coef(band_t'(u_side))),
        .side_in(u_side),
        .out_vld(x_vld), .res(x_raw), .side_out(x_side)
    );

    assign x_band = band_t'(x_side);
    assign x_sel  = x_pick(x_band, x_raw);

    // chromaticity y
    logic        y_vld;
    q_t          y_raw;
    logic [34:0] y_side;
    band_t       y_band;
    q_t          x_y, y_sel, y_div, z_q, z_mag;
    logic [1:0][48:0] xz_num;
    logic        xz_vld;
    logic [1:0][26:0] xz_quo;
    logic        xz_zneg;

    cct_cubic #(.SIDE_W(35)) u_cubic_y (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_vld(x_vld), .v(x_sel), .coef(y_coef(x_band)),
        .side_in({x_side, x_sel}),
        .out_vld(y_vld), .res(y_raw), .side_out(y_side)
    );

    assign y_band = band_t'(y_side[34:32]);
    assign x_y    = q_t'(y_side[31:0]);
    assign y_sel  = y_pick(y_band, y_raw);
    assign y_div  = (y_sel < 32'sd1) ? 32'sd1 : y_sel;
    assign z_q    = QONE - x_y - y_sel;
    assign z_mag  = z_q[31] ? -z_q : z_q;

    assign xz_num[0] = {x_y[24:0], 24'd0} + 49'(y_div[24:1]);
    assign xz_num[1] = {z_mag[24:0], 24'd0} + 49'(y_div[24:1]);

    cct_div #(
        .NW(49), .DW(25), .QB(27), .LANES(2), .SIDE_W(1)
    ) u_div_xyz (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_vld(y_vld), .num(xz_num), .den(y_div[24:0]), .side_in(z_q[31]),
        .out_vld(xz_vld), .quo(xz_quo), .side_out(xz_zneg)
    );

    // matrix, sums and maximum
    q_t   bx, bz;
    q_t   prod_reg [6];
    q_t   sum_reg  [3];
    q_t   rgb_reg  [3];
    q_t   mx_reg;
    logic big_reg;
    logic [2:0] mat_vld_reg;
    q_t   mx_next;

    assign bx = q_t'({5'd0, xz_quo[0]});
    assign bz = xz_zneg ? -q_t'({5'd0, xz_quo[1]}) : q_t'({5'd0, xz_quo[1]});

    always_comb
    begin
        mx_next = sum_reg[0];
        if (sum_reg[1] > mx_next)
            mx_next = sum_reg[1];
        if (sum_reg[2] > mx_next)
            mx_next = sum_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= qmul(MRX, bx);
            prod_reg[1] <= qmul(MRZ, bz);
            prod_reg[2] <= qmul(MGX, bx);
            prod_reg[3] <= qmul(MGZ, bz);
            prod_reg[4] <= qmul(MBX, bx);
            prod_reg[5] <= qmul(MBZ, bz);

            sum_reg[0] <= prod_reg[0] + MRY + prod_reg[1];
            sum_reg[1] <= prod_reg[2] + MGY + prod_reg[3];
            sum_reg[2] <= prod_reg[4] + MBY + prod_reg[5];

            rgb_reg[0] <= sum_reg[0];
            rgb_reg[1] <= sum_reg[1];
            rgb_reg[2] <= sum_reg[2];
            mx_reg     <= mx_next;
            big_reg    <= mx_next > QONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mat_vld_reg <= '0;
        else if (adv)
            mat_vld_reg <= {mat_vld_reg[1:0], xz_vld};
    end

    // normalise by the maximum
    logic [2:0][54:0] n_num;
    logic             n_vld;
    logic [2:0][24:0] n_quo;
    logic [96:0]      n_side;
    q_t               fin [3];
    logic [2:0][OUT_BITS-1:0] res;

    for (genvar c = 0; c < 3; c++) begin : g_norm
        assign n_num[c] = (rgb_reg[c] > 0)
                        ? ({rgb_reg[c][30:0], 24'd0} + 55'(mx_reg[30:1])) : '0;
        assign fin[c]   = n_side[96] ? q_t'({7'd0, n_quo[c]})
                                     : q_t'(n_side[32*c +: 32]);
        assign res[c]   = to_out(fin[c]);
    end

    cct_div #(
        .NW(55), .DW(31), .QB(25), .LANES(3), .SIDE_W(97)
    ) u_div_norm (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_vld(mat_vld_reg[2]), .num(n_num), .den(mx_reg[30:0]),
        .side_in({big_reg, rgb_reg[2], rgb_reg[1], rgb_reg[0]}),
        .out_vld(n_vld), .quo(n_quo), .side_out(n_side)
    );

    // output register and skid
    logic pop;
    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (n_vld)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (n_vld)
        begin
            if (!out_valid_reg || pop)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign red       = out_reg[0];
    assign green     = out_reg[1];
    assign blue      = out_reg[2];

    `CCT_ASSERT_NOW(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid full with empty output")
    `CCT_ASSERT_NEXT(a_skid_drains, skid_valid_reg && !out_stall, !skid_valid_reg, "skid not drained")
    `CCT_ASSERT_NEXT(a_empty_no_skid, !out_valid_reg, !skid_valid_reg, "skid filled past empty output")

endmodule

`default_nettype wire

### sim/color_temperature_to_rgb_tb.sv
// ----------------------------------------------------------------------------
// color_temperature_to_rgb testbench
// Drives kelvin beats through the colour temperature block with random idling
// on both sides, predicts each RGB triple in Q24 fixed point and checks every
// result beat in order against the predicted triple.
// ----------------------------------------------------------------------------
`default_nettype none

module color_temperature_to_rgb_tb;

    localparam int OB         = 16;
    localparam int LATENCY    = 86;
    localparam int WATCHDOG   = 4000;
    localparam longint Q1     = 64'sd16777216;

    typedef struct {
        logic [OB-1:0] r;
        logic [OB-1:0] g;
        logic [OB-1:0] b;
    } rgb_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [15:0]   kelvin;
    logic          out_valid;
    logic          out_stall;
    logic [OB-1:0] red;
    logic [OB-1:0] green;
    logic [OB-1:0] blue;

    rgb_t   pending_rgb[$];
    int     errors;
    int     beats_in;
    int     beats_out;
    int     idle_cycles;
    bit     sink_idle_on;
    bit     src_idle_on;

    color_temperature_to_rgb #(.OUT_BITS(OB)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .kelvin(kelvin),
        .out_valid(out_valid), .out_stall(out_stall),
        .red(red), .green(green), .blue(blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint qfx(input longint n, input longint d);
        return (n * Q1 + d / 2) / d;
    endfunction

    function automatic longint fxmul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0)
            return (p + Q1 / 2) / Q1;
        return -(((-p) + Q1 / 2) / Q1);
    endfunction

    function automatic longint fxdiv(input longint a, input longint b);
        longint n;
        if (b < 1)
            b = 1;
        n = a * Q1;
        if (n >= 0)
            return (n + b / 2) / b;
        return -(((-n) + b / 2) / b);
    endfunction

    function automatic longint horner(input longint c3, input longint c2,
                                      input longint c1, input longint c0,
                                      input longint v);
        longint acc;
        acc = fxmul(c3, v) + c2;
        acc = fxmul(acc, v) + c1;
        return fxmul(acc, v) + c0;
    endfunction

    function automatic logic [OB-1:0] to_fraction(input longint v);
        longint r;
        if (v <= 0)
            return '0;
        r = ((v << OB) + Q1 / 2) >>> 24;
        if (r > (64'sd1 << OB) - 1)
            return '1;
        return r[OB-1:0];
    endfunction

    function automatic rgb_t kelvin_to_rgb(input logic [15:0] k);
        longint t, u, x, y, bx, bz, r, g, b, mx;
        rgb_t   res;
        t = k;
        if (t < 1000)
            t = 1000;
        if (t > 40000)
            t = 40000;
        u = (1000 * Q1 + t / 2) / t;
        if (t >= 1667 && t <= 4000)
            x = horner(-qfx(2661239, 10000000), -qfx(2343580, 10000000),
                       qfx(8776956, 10000000), qfx(179910, 1000000), u);
        else if (t > 4000 && t <= 25000)
            x = horner(-qfx(30258469, 10000000), qfx(21070379, 10000000),
                       qfx(2226347, 10000000), qfx(240390, 1000000), u);
        else
            x = (t > 25000) ? qfx(239, 1000) : qfx(642, 1000);
        if (t >= 1667 && t <= 2222)
            y = horner(-qfx(11063814, 10000000), -qfx(13481102, 10000000),
                       qfx(21855580, 10000000), -qfx(202196, 1000000), x);
        else if (t > 2222 && t <= 4000)
            y = horner(-qfx(9549476, 10000000), -qfx(13741859, 10000000),
                       qfx(20913701, 10000000), -qfx(167488, 1000000), x);
        else if (t > 4000 && t <= 25000)
            y = horner(qfx(30817580, 10000000), -qfx(58733867, 10000000),
                       qfx(3751129, 1000000), -qfx(370015, 1000000), x);
        else
            y = (t > 25000) ? qfx(246, 1000) : qfx(376, 1000);
        bx = fxdiv(x, y);
        bz = fxdiv(Q1 - x - y, y);
        r = fxmul(qfx(32404542, 10000000), bx) - qfx(15371385, 10000000)
            + fxmul(-qfx(4985314, 10000000), bz);
        g = fxmul(-qfx(9692660, 10000000), bx) + qfx(18760108, 10000000)
            + fxmul(qfx(415560, 10000000), bz);
        b = fxmul(qfx(556434, 10000000), bx) - qfx(2040259, 10000000)
            + fxmul(qfx(10572252, 10000000), bz);
        mx = r;
        if (g > mx)
            mx = g;
        if (b > mx)
            mx = b;
        if (mx > Q1)
        begin
            r = fxdiv(r, mx);
            g = fxdiv(g, mx);
            b = fxdiv(b, mx);
        end
        res.r = to_fraction(r);
        res.g = to_fraction(g);
        res.b = to_fraction(b);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_out, what, got, want);
        errors++;
    endtask

    // send one kelvin beat, with an optional idle burst first
    task automatic send_kelvin(input logic [15:0] k);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kelvin   <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_rgb.push_back(kelvin_to_rgb(k));
        beats_in++;
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rgb.size() == 0)
                report_mismatch("unexpected beat, red", red, 0);
            else
            begin
                want = pending_rgb.pop_front();
                if (red !== want.r)
                    report_mismatch("red", red, want.r);
                if (green !== want.g)
                    report_mismatch("green", green, want.g);
                if (blue !== want.b)
                    report_mismatch("blue", blue, want.b);
            end
            beats_out++;
        end
    end

    // receiver stall bursts
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("watchdog expired");
            $display("color_temperature_to_rgb test failed");
            $finish;
        end
    end

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_extremes_and_edges();
        logic [15:0] pts[] = '{16'd0, 16'd999, 16'd1000, 16'd1001, 16'd1666, 16'd1667,
                               16'd1668, 16'd2222, 16'd2223, 16'd3999, 16'd4000,
                               16'd4001, 16'd6500, 16'd24999, 16'd25000, 16'd25001,
                               16'd39999, 16'd40000, 16'd40001, 16'hFFFF,
                               16'h5555, 16'hAAAA};
        foreach (pts[i])
            send_kelvin(pts[i]);
    endtask

    task automatic test_pause_until_drained();
        send_kelvin(16'd2700);
        send_kelvin(16'd5000);
        drain_results();
        send_kelvin(16'd10000);
    endtask

    task automatic test_random_kelvin(input int count);
        logic [15:0] k;
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0:       k = 16'($urandom);
                1:       k = 16'($urandom_range(0, 1100));
                2:       k = 16'($urandom_range(1600, 1700));
                3:       k = 16'($urandom_range(2150, 2300));
                4:       k = 16'($urandom_range(3900, 4100));
                5:       k = 16'($urandom_range(24900, 25100));
                6:       k = 16'($urandom_range(39900, 65535));
                default: k = 16'($urandom_range(1000, 40000));
            endcase
            send_kelvin(k);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kelvin       = '0;
        errors       = 0;
        beats_in     = 0;
        beats_out    = 0;
        idle_cycles  = 0;
        sink_idle_on = 1'b1;
        src_idle_on  = 1'b1;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes_and_edges();
        test_pause_until_drained();
        test_random_kelvin(1500);
        sink_idle_on = 1'b0;
        src_idle_on  = 1'b0;
        test_random_kelvin(425);
        drain_results();
        repeat (LATENCY + 10) @(negedge clk);
        $display("Covered %0d kelvin beats in, %0d RGB beats out, across all bands,", beats_in,
                 beats_out);
        $display("band edges, clamps and random idling on both sides.");
        if (errors == 0 && pending_rgb.size() == 0)
            $display("color_temperature_to_rgb test passed");
        else
            $display("color_temperature_to_rgb test failed");
        $finish;
    end

endmodule

`default_nettype wire
